FILE: sv/accumulator_integer_alu_core_assert.svh
// ----------------------------------------------------------------------------
// Accumulator integer ALU core - assertion macros
// Small wrappers so that each check reads as one line in the RTL.
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_INTEGER_ALU_CORE_ASSERT_SVH
`define ACCUMULATOR_INTEGER_ALU_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define AIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define AIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) \
		(ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/aia_pkg.sv
// ----------------------------------------------------------------------------
// aia_pkg
// Shared types for the accumulator integer ALU: operation codes, sequencer
// states and the request/response bundles between core and iterative unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aia_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W  = $clog2(DATA_W);

	// Operation codes as carried in the op field
	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_POW  = 3'd4,
		OP_MOD  = 3'd5,
		OP_NONE = 3'd6
	} op_t;

	// Iterative unit sequencer
	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_DIV,
		U_FIX,
		U_PMUL,
		U_PSQ,
		U_DONE
	} unit_state_t;

	// Core to unit
	typedef struct packed {
		logic start;
		logic ack;
		op_t  op;
	} unit_req_t;

	// Unit to core
	typedef struct packed {
		logic              done;
		logic              keep;
		logic              div_zero;
		logic [DATA_W-1:0] value;
	} unit_resp_t;

endpackage

`default_nettype wire

FILE: sv/aia_iter_unit.sv
// ----------------------------------------------------------------------------
// aia_iter_unit
// Iterative arithmetic unit: one shared 32x32 multiplier for multiply and
// square-and-multiply power, one restoring divider step per cycle for
// divide and modulo, all under a small sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aia_iter_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  aia_pkg::unit_req_t         req,
	input  wire  [aia_pkg::DATA_W-1:0]       a,
	input  wire  [aia_pkg::DATA_W-1:0]       b,
	output aia_pkg::unit_resp_t              resp
);
	import aia_pkg::*;

	unit_state_t        state_q, state_d;
	op_t                op_q;
	logic [DATA_W-1:0]  res_q;
	logic               keep_q;
	logic               dz_q;
	logic [DATA_W-1:0]  quo_q;
	logic [DATA_W-1:0]  rem_q;
	logic [DATA_W-1:0]  dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [DATA_W-1:0]  pacc_q;
	logic [DATA_W-1:0]  sq_q;
	logic [DATA_W-1:0]  exp_q;

	logic [DATA_W-1:0]  mag_a, mag_b;
	logic [DATA_W-1:0]  mul_x, mul_p;
	logic [DATA_W:0]    trial;
	logic [DATA_W-1:0]  fix_sel;

	// Operand magnitudes for the divider
	assign mag_a = a[DATA_W-1] ? (DATA_W'(0) - a) : a;
	assign mag_b = b[DATA_W-1] ? (DATA_W'(0) - b) : b;

	// Shared multiplier, low word only
	assign mul_x = (state_q == U_PSQ) ? sq_q : pacc_q;
	assign mul_p = mul_x * sq_q;

	// Restoring divider trial subtract
	assign trial = {rem_q, quo_q[DATA_W-1]} - {1'b0, dvs_q};

	// Sign fix-up source
	assign fix_sel = (op_q == OP_DIV) ? quo_q : rem_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					case (req.op)
						OP_MUL:  state_d = U_MUL;
						OP_DIV, OP_MOD: begin
							state_d = (b == '0) ? U_DONE : U_DIV;
						end
						OP_POW:  state_d = b[DATA_W-1] ? U_DONE : U_PMUL;
						default: state_d = U_DONE;
					endcase
				end
			end
			U_MUL:  state_d = U_DONE;
			U_DIV:  state_d = (cnt_q == '0) ? U_FIX : U_DIV;
			U_FIX:  state_d = U_DONE;
			U_PMUL: state_d = (exp_q == '0) ? U_DONE : U_PSQ;
			U_PSQ:  state_d = U_PMUL;
			U_DONE: state_d = req.ack ? U_IDLE : U_DONE;
			default: state_d = U_IDLE;
		endcase
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					keep_q <= 1'b0;
					dz_q   <= 1'b0;
					case (req.op)
						OP_ADD: res_q <= a + b;
						OP_SUB: res_q <= a - b;
						OP_MUL: begin
							pacc_q <= a;
							sq_q   <= b;
						end
						OP_DIV, OP_MOD: begin
							if (b == '0) begin
								keep_q <= 1'b1;
								dz_q   <= 1'b1;
							end
							quo_q <= mag_a;
							dvs_q <= mag_b;
							rem_q <= '0;
							cnt_q <= CNT_W'(DATA_W - 1);
							neg_q <= (req.op == OP_DIV) ? (a[DATA_W-1] ^ b[DATA_W-1])
								: a[DATA_W-1];
						end
						OP_POW: begin
							res_q  <= DATA_W'(1);
							pacc_q <= DATA_W'(1);
							sq_q   <= a;
							exp_q  <= b;
						end
						default: keep_q <= 1'b1;
					endcase
				end
			end
			U_MUL: res_q <= mul_p;
			U_DIV: begin
				// one quotient bit per cycle
				if (!trial[DATA_W]) begin
					rem_q <= trial[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - CNT_W'(1);
			end
			U_FIX: res_q <= neg_q ? (DATA_W'(0) - fix_sel) : fix_sel;
			U_PMUL: begin
				if (exp_q == '0) begin
					res_q <= pacc_q;
				end else if (exp_q[0]) begin
					pacc_q <= mul_p;
				end
			end
			U_PSQ: begin
				sq_q  <= mul_p;
				exp_q <= exp_q >> 1;
			end
			default: ;
		endcase
	end

	// Response bundle
	always_comb begin
		resp.done     = (state_q == U_DONE);
		resp.keep     = keep_q;
		resp.div_zero = dz_q;
		resp.value    = res_q;
	end

endmodule

`default_nettype wire

FILE: sv/accumulator_integer_alu_core.sv
// ----------------------------------------------------------------------------
// accumulator_integer_alu_core
// Signed 32-bit calculator with an accumulator. Input words carry op,
// use_acc, operand_a and operand_b under in_valid/in_stall; each word gives
// one result word (value, div_zero) under out_valid/out_stall, and value
// also becomes the new accumulator. Arithmetic wraps modulo 2^32.
// In the iterative unit, add, sub, none, a refused divide and a negative
// exponent go straight to done; multiply uses the shared multiplier once,
// divide and modulo take 32 restoring steps plus a sign fix, and power runs
// square-and-multiply up to the top set exponent bit, the single shared
// multiplier doing one multiply or one square per cycle. in_stall is high
// from acceptance until the result is loaded into the output register, so
// one word is in flight at a time and the next word can be taken in the
// cycle after that; a new word can be taken while out_valid waits.
// Reset clears the accumulator to zero and empties the output register.
// While out_stall is high and the output register is full, a finished result waits in the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "accumulator_integer_alu_core_assert.svh"

module accumulator_integer_alu_core (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [2:0]                           op,
	input  wire                                  use_acc,
	input  wire  signed [aia_pkg::DATA_W-1:0]    operand_a,
	input  wire  signed [aia_pkg::DATA_W-1:0]    operand_b,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic signed [aia_pkg::DATA_W-1:0]    value,
	output logic                                 div_zero
);
	import aia_pkg::*;

	logic               busy_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  value_q;
	logic               div_zero_q;
	logic [DATA_W-1:0]  acc_q;

	logic               in_accept;
	logic               res_take;
	logic [DATA_W-1:0]  first_opd;
	logic [DATA_W-1:0]  new_value;
	unit_req_t          req;
	unit_resp_t         resp;

	assign in_accept = in_valid && !busy_q;
	assign res_take  = resp.done && (!out_valid_q || !out_stall);
	assign first_opd = use_acc ? acc_q : operand_a;
	assign new_value = resp.keep ? acc_q : resp.value;

	always_comb begin
		req.start = in_accept;
		req.ack   = res_take;
		req.op    = op_t'(op);
	end

	aia_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.a      (first_opd),
		.b      (operand_b),
		.resp   (resp)
	);

	// Busy flag, output word valid and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (in_accept) begin
				busy_q <= 1'b1;
			end else if (res_take) begin
				busy_q <= 1'b0;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
				acc_q       <= new_value;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (res_take) begin
			value_q    <= new_value;
			div_zero_q <= resp.div_zero;
		end
	end

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign div_zero  = div_zero_q;

	// Checks
	`AIA_ASSERT_NXT(a_accept_busy, clk, arst_n, in_accept, busy_q, "not busy after accept")
	`AIA_ASSERT_NXT(a_take_valid, clk, arst_n, res_take, out_valid_q, "result not presented")
	`AIA_ASSERT_IMP(a_acc_match, clk, arst_n, out_valid_q, acc_q == value_q, "acc mismatch")
	`AIA_ASSERT_IMP(a_done_busy, clk, arst_n, resp.done, busy_q, "unit done while idle")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - accumulator integer ALU core regression
// Drives calculator words (op, use_acc, operand_a, operand_b) into the core
// and checks every result word against a local accumulator predictor. A
// short directed set covers the wrap, sign and divide-by-zero corners, then
// random words follow in blocks that rotate through the idle and stall mixes.
// ----------------------------------------------------------------------------

module tb_top;
	import aia_pkg::*;

	// op code 7 is unused by the core and must behave like OP_NONE
	localparam logic [2:0]  OP_UNUSED    = 3'd7;
	localparam int unsigned RANDOM_WORDS = 1925;
	localparam int unsigned BLOCK_WORDS  = 100;
	localparam int unsigned STUCK_LIMIT  = 4000;
	localparam int unsigned TAIL_CYCLES  = 100;

	// idle mixes
	localparam int unsigned MODE_FLAT  = 0;
	localparam int unsigned MODE_SEND  = 1;
	localparam int unsigned MODE_RECV  = 2;
	localparam int unsigned MODE_BOTH  = 3;

	typedef struct {
		logic [2:0]  code;
		logic        sel_acc;
		logic [31:0] a;
		logic [31:0] b;
		int unsigned mode;
	} calc_word_t;

	typedef struct {
		logic [31:0] result;
		logic        dz;
	} calc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  op = 3'd0;
	logic        use_acc = 1'b0;
	logic [31:0] operand_a = 32'd0;
	logic [31:0] operand_b = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] value;
	logic        div_zero;

	calc_word_t   pending_words[$];
	calc_result_t expected_results[$];
	calc_word_t   held_word;
	logic [31:0]  model_acc = 32'd0;
	int unsigned  cur_mode = MODE_FLAT;
	int unsigned  stuck_cycles = 0;
	int unsigned  failures = 0;

	accumulator_integer_alu_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.use_acc   (use_acc),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.div_zero  (div_zero)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_failure(input string what);
		failures++;
		$display("%0t ns ERROR: %s", $time, what);
	endtask

	// Predictor: applies one accepted word to the local accumulator
	function automatic calc_result_t apply_calc_word(calc_word_t w);
		calc_result_t r;
		logic [31:0]  lhs;
		logic [31:0]  mag_a;
		logic [31:0]  mag_b;
		logic [31:0]  quot;
		logic [31:0]  rem;
		logic [31:0]  sq;
		logic [31:0]  expo;
		int           k;
		lhs = w.sel_acc ? model_acc : w.a;
		r.result = model_acc;
		r.dz = 1'b0;
		mag_a = lhs[31] ? (32'd0 - lhs) : lhs;
		mag_b = w.b[31] ? (32'd0 - w.b) : w.b;
		case (w.code)
		OP_ADD: r.result = lhs + w.b;
		OP_SUB: r.result = lhs - w.b;
		OP_MUL: r.result = lhs * w.b;
		OP_DIV, OP_MOD: begin
			if (w.b == 32'd0) begin
				r.dz = 1'b1;
			end else if (w.code == OP_DIV) begin
				quot = mag_a / mag_b;
				r.result = (lhs[31] ^ w.b[31]) ? (32'd0 - quot) : quot;
			end else begin
				// remainder follows the sign of the dividend
				rem = mag_a % mag_b;
				r.result = lhs[31] ? (32'd0 - rem) : rem;
			end
		end
		OP_POW: begin
			r.result = 32'd1;
			if (!w.b[31]) begin
				sq = lhs;
				expo = w.b;
				for (k = 0; k < 32; k++) begin
					if (expo[0])
						r.result = r.result * sq;
					sq = sq * sq;
					expo = expo >> 1;
				end
			end
		end
		default: ;
		endcase
		model_acc = r.result;
		return r;
	endfunction

	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(9))
		0: begin
			case ($urandom_range(4))
			0: v = 32'd0;
			1: v = 32'd1;
			2: v = 32'hFFFF_FFFF;
			3: v = 32'h7FFF_FFFF;
			default: v = 32'h8000_0000;
			endcase
		end
		1, 2, 3: v = $urandom_range(200) - 32'd100;
		default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic calc_word_t make_random_word(int unsigned mode);
		calc_word_t  w;
		int unsigned sel;
		w.code = 3'($urandom_range(7));
		w.sel_acc = 1'($urandom_range(1));
		w.a = pick_operand();
		w.mode = mode;
		sel = $urandom_range(99);
		case (w.code)
		OP_DIV, OP_MOD: begin
			if (sel < 10)
				w.b = 32'd0;
			else if (sel < 20)
				w.b = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
			else if (sel < 50)
				w.b = $urandom_range(200) - 32'd100;
			else
				w.b = $urandom;
		end
		OP_POW: begin
			// mostly short exponents so the square-and-multiply result survives
			if (sel < 55)
				w.b = $urandom_range(40);
			else if (sel < 70)
				w.b = {1'b1, 31'($urandom)};
			else if (sel < 85)
				w.b = $urandom;
			else
				w.b = {1'b0, 31'($urandom)};
		end
		default: w.b = pick_operand();
		endcase
		return w;
	endfunction

	task automatic queue_word(input logic [2:0] code, input logic sel_acc,
			input logic [31:0] a, input logic [31:0] b);
		calc_word_t w;
		w.code = code;
		w.sel_acc = sel_acc;
		w.a = a;
		w.b = b;
		w.mode = MODE_FLAT;
		pending_words.push_back(w);
	endtask

	function automatic int unsigned send_idle_pct(int unsigned mode);
		return (mode == MODE_SEND) ? 45 : (mode == MODE_BOTH) ? 18 : 0;
	endfunction

	function automatic int unsigned recv_stall_pct(int unsigned mode);
		return (mode == MODE_RECV) ? 45 : (mode == MODE_BOTH) ? 18 : 0;
	endfunction

	// Driver: predicts on acceptance, then offers the next pending word
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_results.push_back(apply_calc_word(held_word));
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 &&
						$urandom_range(99) >= send_idle_pct(pending_words[0].mode)) begin
					held_word = pending_words.pop_front();
					cur_mode <= held_word.mode;
					in_valid <= 1'b1;
					op <= held_word.code;
					use_acc <= held_word.sel_acc;
					operand_a <= held_word.a;
					operand_b <= held_word.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks accepted result words and drives the output stall
	always @(posedge clk) begin
		calc_result_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_failure($sformatf("unexpected result word value=%08h div_zero=%b",
						value, div_zero));
				end else begin
					exp_r = expected_results.pop_front();
					if (value !== exp_r.result)
						report_failure($sformatf("value %08h, predicted %08h",
							value, exp_r.result));
					if (div_zero !== exp_r.dz)
						report_failure($sformatf("div_zero %b, predicted %b",
							div_zero, exp_r.dz));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct(cur_mode));
		end
	end

	// Watchdog: cycles since any word moved on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int unsigned i;

		// wrap, sign and divide-by-zero corners
		queue_word(OP_ADD, 1'b0, 32'h7FFF_FFFF, 32'd1);
		queue_word(OP_SUB, 1'b0, 32'h8000_0000, 32'd1);
		queue_word(OP_MUL, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_word(OP_DIV, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_word(OP_MOD, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
		queue_word(OP_DIV, 1'b1, 32'h1234_5678, 32'd0);
		queue_word(OP_ADD, 1'b0, 32'hFFFF_FFF9, 32'd0);
		queue_word(OP_MOD, 1'b1, 32'hFFFF_FFFF, 32'd0);
		queue_word(OP_DIV, 1'b1, 32'hDEAD_BEEF, 32'd2);
		queue_word(OP_MOD, 1'b0, 32'hFFFF_FFF9, 32'd2);
		queue_word(OP_MOD, 1'b0, 32'd7, 32'hFFFF_FFFE);
		queue_word(OP_DIV, 1'b0, 32'd7, 32'hFFFF_FFFE);
		queue_word(OP_DIV, 1'b0, 32'h8000_0000, 32'd1);
		queue_word(OP_POW, 1'b0, 32'd3, 32'hFFFF_FFFF);
		queue_word(OP_POW, 1'b0, 32'd2, 32'd0);
		queue_word(OP_POW, 1'b0, 32'd2, 32'd31);
		queue_word(OP_POW, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_word(OP_POW, 1'b1, 32'h5555_5555, 32'd3);
		queue_word(OP_ADD, 1'b0, 32'd3, 32'd0);
		queue_word(OP_POW, 1'b1, 32'd0, 32'd31);
		queue_word(OP_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(OP_UNUSED, 1'b0, 32'hFFFF_FFFF, 32'd0);
		queue_word(OP_MUL, 1'b1, 32'hAAAA_AAAA, 32'h8000_0000);
		queue_word(OP_DIV, 1'b0, 32'd0, 32'd0);
		queue_word(OP_NONE, 1'b0, 32'd0, 32'd0);

		// random words, idle mix rotating every block
		for (i = 0; i < RANDOM_WORDS; i++)
			pending_words.push_back(make_random_word((i / BLOCK_WORDS) % 4));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (!((pending_words.size() == 0 && !in_valid && expected_results.size() == 0)
				|| stuck_cycles >= STUCK_LIMIT))
			@(posedge clk);

		if (stuck_cycles >= STUCK_LIMIT)
			report_failure($sformatf("watchdog: nothing moved for %0d cycles", STUCK_LIMIT));
		else
			repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_failure($sformatf("%0d result words never arrived",
				expected_results.size()));

		if (failures == 0)
			$display("accumulator_integer_alu_core regression: pass");
		else
			$display("accumulator_integer_alu_core regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+sv
sv/aia_pkg.sv
sv/aia_iter_unit.sv
sv/accumulator_integer_alu_core.sv
bench/tb_top.sv
